FILE: rtl/core/hzfg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hzfg_pkg
// Shared types, constants and codes of the haptic zone force-gain block.
// ----------------------------------------------------------------------------
package hzfg_pkg;

  localparam int CHANNELS = 2;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int DIST_W  = 16;
  localparam int FORCE_W = 16;
  localparam int COEF_W  = 24;
  localparam int ZONE_W  = 3;
  localparam int IDX_W   = 8;

  localparam logic [FORCE_W-1:0] DEFAULT_GAIN = FORCE_W'(3116);

  localparam logic [ZONE_W-1:0] ZONE_OUTSIDE = 3'd0;
  localparam logic [ZONE_W-1:0] ZONE_OUTER   = 3'd1;
  localparam logic [ZONE_W-1:0] ZONE_CENTER  = 3'd2;
  localparam logic [ZONE_W-1:0] ZONE_INNER   = 3'd3;
  localparam logic [ZONE_W-1:0] ZONE_INSIDE  = 3'd4;

  localparam logic [IDX_W-1:0] REG_OUTER_RADIUS    = 8'd0;
  localparam logic [IDX_W-1:0] REG_OUTER_BAND_EDGE = 8'd1;
  localparam logic [IDX_W-1:0] REG_INNER_RADIUS    = 8'd2;
  localparam logic [IDX_W-1:0] REG_INNER_BAND_EDGE = 8'd3;
  localparam logic [IDX_W-1:0] REG_SLOPE           = 8'd4;
  localparam logic [IDX_W-1:0] REG_OUTER_INTERCEPT = 8'd5;
  localparam logic [IDX_W-1:0] REG_INNER_INTERCEPT = 8'd6;
  localparam logic [IDX_W-1:0] REG_FORCE_LIMIT     = 8'd7;

  typedef struct packed {
    logic [DIST_W-1:0]         outer_radius;
    logic [DIST_W-1:0]         outer_band_edge;
    logic [DIST_W-1:0]         inner_radius;
    logic [DIST_W-1:0]         inner_band_edge;
    logic signed [COEF_W-1:0]  slope;
    logic signed [COEF_W-1:0]  outer_intercept;
    logic signed [COEF_W-1:0]  inner_intercept;
    logic [FORCE_W-1:0]        force_limit;
  } cfg_t;

  typedef struct packed {
    logic [ZONE_W-1:0] zone_now;
    logic [ZONE_W-1:0] zone_before;
  } zstate_t;

  localparam int ZSTATE_W = $bits(zstate_t);

endpackage

FILE: rtl/core/hzfg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hzfg_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module hzfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/hzfg_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hzfg_cfg
// Configuration register file: thresholds, ramp coefficients, force limit.
// ----------------------------------------------------------------------------
module hzfg_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hzfg_pkg::IDX_W-1:0]  cfg_index,
  input  logic [hzfg_pkg::COEF_W-1:0] cfg_data,
  output hzfg_pkg::cfg_t            cfg
);
  import hzfg_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.outer_radius    <= DIST_W'(2458);
      cfg.outer_band_edge <= DIST_W'(3113);
      cfg.inner_radius    <= DIST_W'(1475);
      cfg.inner_band_edge <= DIST_W'(819);
      cfg.slope           <= COEF_W'(-96000);
      cfg.outer_intercept <= COEF_W'(18240);
      cfg.inner_intercept <= COEF_W'(8640);
      cfg.force_limit     <= FORCE_W'(3840);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OUTER_RADIUS:    cfg.outer_radius    <= cfg_data[DIST_W-1:0];
        REG_OUTER_BAND_EDGE: cfg.outer_band_edge <= cfg_data[DIST_W-1:0];
        REG_INNER_RADIUS:    cfg.inner_radius    <= cfg_data[DIST_W-1:0];
        REG_INNER_BAND_EDGE: cfg.inner_band_edge <= cfg_data[DIST_W-1:0];
        REG_SLOPE:           cfg.slope           <= $signed(cfg_data);
        REG_OUTER_INTERCEPT: cfg.outer_intercept <= $signed(cfg_data);
        REG_INNER_INTERCEPT: cfg.inner_intercept <= $signed(cfg_data);
        REG_FORCE_LIMIT:     cfg.force_limit     <= cfg_data[FORCE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/hzfg_zone.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hzfg_zone
// Zone transition and gain selection, including the shared ramp multiply.
// ----------------------------------------------------------------------------
module hzfg_zone (
  input  hzfg_pkg::cfg_t                cfg,
  input  logic [hzfg_pkg::DIST_W-1:0]   distance,
  input  hzfg_pkg::zstate_t             zs,
  input  logic                          attached,
  output logic [hzfg_pkg::FORCE_W-1:0]  gain,
  output logic [hzfg_pkg::ZONE_W-1:0]   zone
);
  import hzfg_pkg::*;

  localparam int PROD_W = COEF_W + DIST_W + 1;
  localparam int Q_W    = PROD_W - 14;
  localparam int SUM_W  = Q_W + 1;

  logic [DIST_W-1:0]        r1, r1p, r2, r2p;
  logic [ZONE_W-1:0]        z, prev;
  logic                     use_outer;
  logic signed [COEF_W-1:0] icpt;
  logic signed [PROD_W-1:0] prod;
  logic signed [Q_W-1:0]    q;
  logic signed [SUM_W-1:0]  f;
  logic signed [SUM_W-1:0]  lim;
  logic [FORCE_W-1:0]       ramp;

  assign r1   = cfg.outer_radius;
  assign r1p  = cfg.outer_band_edge;
  assign r2   = cfg.inner_radius;
  assign r2p  = cfg.inner_band_edge;
  assign z    = zs.zone_now;
  assign prev = zs.zone_before;

  assign use_outer = (z == ZONE_OUTER) || ((z == ZONE_CENTER) && (distance >= r1));
  assign icpt = use_outer ? cfg.outer_intercept : cfg.inner_intercept;
  assign prod = PROD_W'(cfg.slope) * $signed({1'b0, distance});
  assign q    = prod[PROD_W-1:14];
  assign f    = SUM_W'(q) + SUM_W'(icpt);
  assign lim  = $signed({{(SUM_W-FORCE_W){1'b0}}, cfg.force_limit});

  always_comb begin
    if (f >= lim) begin
      ramp = cfg.force_limit;
    end else if (f <= 0) begin
      ramp = '0;
    end else begin
      ramp = f[FORCE_W-1:0];
    end
  end

  always_comb begin
    gain = DEFAULT_GAIN;
    zone = z;
    if (attached) begin
      gain = cfg.force_limit;
    end else begin
      case (z)
        ZONE_OUTSIDE: begin
          if (distance > r1p) begin
            gain = '0;
          end else if (distance >= r1) begin
            zone = ZONE_OUTER;
            gain = '0;
          end
        end
        ZONE_OUTER: begin
          if (distance <= r1p && distance >= r1) begin
            if (prev == ZONE_CENTER) begin
              gain = ramp;
            end else if (prev == ZONE_OUTSIDE) begin
              gain = '0;
            end
          end else begin
            gain = '0;
            zone = (distance < r1) ? ZONE_CENTER : ZONE_OUTSIDE;
          end
        end
        ZONE_CENTER: begin
          if (distance < r1 && distance > r2) begin
            if (prev == ZONE_OUTER) begin
              gain = '0;
            end else if (prev == ZONE_INNER) begin
              gain = cfg.force_limit;
            end
          end else if (distance >= r1) begin
            zone = ZONE_OUTER;
            gain = (prev == ZONE_INNER) ? ramp : '0;
          end else begin
            zone = ZONE_INNER;
            gain = (prev == ZONE_OUTER) ? ramp : cfg.force_limit;
          end
        end
        ZONE_INNER: begin
          if (distance <= r2 && distance >= r2p) begin
            if (prev == ZONE_CENTER) begin
              gain = ramp;
            end else if (prev == ZONE_INSIDE) begin
              gain = cfg.force_limit;
            end
          end else begin
            gain = cfg.force_limit;
            zone = (distance < r2p) ? ZONE_INSIDE : ZONE_CENTER;
          end
        end
        default: begin
          gain = cfg.force_limit;
          if (distance < r2p) begin
            zone = ZONE_INSIDE;
          end else if (distance <= r2) begin
            zone = ZONE_INNER;
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/haptic_zone_force_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haptic_zone_force_gain
// Per-channel haptic force-gain zone machine with hysteresis.
//
// Input stream: s_tuser carries the channel, s_tdata the distance to target.
// Output stream: m_tdata carries gain and zone, m_tuser the attached flag.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always
// ready, indexes above seven are ignored. Write only while idle.
// One result per input transaction: the zone-state RAM read completes at the
// accepting edge into the compute stage, and the zone logic and ramp multiply
// then load the output register, from which m_tvalid is presented. Throughput
// is one transaction per cycle while m_tready stays high; a state write from
// the previous item is forwarded to a same-channel read.
// The zone state per channel lives in a small RAM with a valid bit per
// entry; reset clears the valid bits and latest distances and reloads the
// default configuration, so every channel starts outside. When m_tready is
// low the output register holds, the compute stage holds behind it, and
// s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module haptic_zone_force_gain (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: distance[15:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // s_tuser: channel[0]
  input  logic        s_tuser,
  // m_tdata: gain[15:0], zone[18:16], zero pad[23:19]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  // m_tuser: attached[0]
  output logic        m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [hzfg_pkg::IDX_W-1:0]  cfg_index,
  input  logic [hzfg_pkg::COEF_W-1:0] cfg_data
);
  import hzfg_pkg::*;

  cfg_t                 cfg;
  logic                 accept;
  logic                 s1_valid;
  logic                 s1_move;
  logic [CH_W-1:0]      s1_ch;
  logic [DIST_W-1:0]    s1_dist;
  logic [CH_W-1:0]      in_ch;
  logic [ZSTATE_W-1:0]  rd_data;
  zstate_t              zs;
  logic                 fwd_valid;
  logic [CH_W-1:0]      fwd_addr;
  zstate_t              fwd_data;
  logic [CHANNELS-1:0]  ent_valid;
  logic [DIST_W-1:0]    last_dist [CHANNELS];
  logic [DIST_W-1:0]    d0, d1;
  logic                 att;
  logic [FORCE_W-1:0]   gain;
  logic [ZONE_W-1:0]    zone;
  zstate_t              wr_state;
  logic                 wr_en;

  hzfg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_ch    = CH_W'(s_tuser);
  assign s1_move  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_move;
  assign accept   = s_tvalid && s_tready;

  hzfg_ram #(
    .WIDTH (ZSTATE_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_ch),
    .wr_data (wr_state),
    .rd_en   (accept),
    .rd_addr (in_ch),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch   <= in_ch;
      s1_dist <= s_tdata;
    end
  end

  always_comb begin
    if (fwd_valid && fwd_addr == s1_ch) begin
      zs = fwd_data;
    end else if (ent_valid[s1_ch]) begin
      zs = zstate_t'(rd_data);
    end else begin
      zs = '{zone_now: ZONE_OUTSIDE, zone_before: ZONE_OUTSIDE};
    end
  end

  // substitute the current sample for its channel's stored distance
  assign d0  = (s1_ch == CH_W'(0)) ? s1_dist : last_dist[0];
  assign d1  = (s1_ch == CH_W'(1)) ? s1_dist : last_dist[1];
  assign att = (d0 < cfg.inner_radius) && (d1 < cfg.inner_radius);

  hzfg_zone u_zone (
    .cfg      (cfg),
    .distance (s1_dist),
    .zs       (zs),
    .attached (att),
    .gain     (gain),
    .zone     (zone)
  );

  always_comb begin
    if (zone != zs.zone_now) begin
      wr_state = '{zone_now: zone, zone_before: zs.zone_now};
    end else begin
      wr_state = zs;
    end
  end

  assign wr_en = s1_move && !att;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      ent_valid <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_dist[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        fwd_valid        <= 1'b1;
        ent_valid[s1_ch] <= 1'b1;
      end
      if (s1_move) begin
        last_dist[s1_ch] <= s1_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= s1_ch;
      fwd_data <= wr_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_tdata <= {5'b0, zone, gain};
      m_tuser <= att;
    end
  end

endmodule

FILE: tb/haptic_zone_force_gain_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haptic_zone_force_gain_tb
// Self-checking bench for the haptic zone force-gain block. Distance samples
// are streamed per channel and a local zone/gain predictor builds the expected
// gain, zone and attached flag for every accepted transaction. Results are
// compared in order. The run covers a directed zone walk, extreme and
// inconsistent register settings, random in/out sweeps under several
// idle/stall mixes, and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module haptic_zone_force_gain_tb;
  import hzfg_pkg::*;

  localparam logic [IDX_W-1:0] REG_PAST_END = 8'd8;
  localparam logic [IDX_W-1:0] REG_UNUSED   = 8'hFF;

  typedef struct packed {
    logic [FORCE_W-1:0] gain;
    logic [ZONE_W-1:0]  zone;
    logic               attached;
  } gain_result_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [DIST_W-1:0]   s_tdata   = '0;
  logic                s_tuser   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [23:0]         m_tdata;
  logic                m_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [COEF_W-1:0]   cfg_data  = '0;

  haptic_zone_force_gain dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  cfg_t               gain_cfg;
  logic [ZONE_W-1:0]  cur_zone  [CHANNELS];
  logic [ZONE_W-1:0]  from_zone [CHANNELS];
  logic [DIST_W-1:0]  seen_dist [CHANNELS];
  gain_result_t       expected_gains[$];
  int                 mismatch_count = 0;
  int                 send_idle_pct  = 0;
  int                 recv_stall_pct = 0;
  int                 hold_off_left  = 0;
  int                 sweep_pos [CHANNELS];
  bit                 sweep_in  [CHANNELS];

  function automatic logic [FORCE_W-1:0] ramp_force(input logic signed [COEF_W-1:0] icpt,
                                                    input logic [DIST_W-1:0] d);
    logic signed [63:0] slope_w;
    logic signed [63:0] icpt_w;
    logic signed [63:0] dist_w;
    logic signed [63:0] sum;
    slope_w = $signed(gain_cfg.slope);
    icpt_w  = icpt;
    dist_w  = {48'd0, d};
    sum     = ((slope_w * dist_w) >>> 14) + icpt_w;
    if (sum >= $signed({48'd0, gain_cfg.force_limit})) return gain_cfg.force_limit;
    if (sum <= 0) return '0;
    return sum[FORCE_W-1:0];
  endfunction

  task automatic predict_force_gain(input logic ch, input logic [DIST_W-1:0] d);
    logic [ZONE_W-1:0]  z;
    logic [ZONE_W-1:0]  prev;
    logic [ZONE_W-1:0]  nz;
    logic [FORCE_W-1:0] g;
    logic               att;
    logic [DIST_W-1:0]  r1, r1p, r2, r2p;
    r1  = gain_cfg.outer_radius;
    r1p = gain_cfg.outer_band_edge;
    r2  = gain_cfg.inner_radius;
    r2p = gain_cfg.inner_band_edge;
    seen_dist[ch] = d;
    att  = (seen_dist[0] < r2) && (seen_dist[1] < r2);
    z    = cur_zone[ch];
    prev = from_zone[ch];
    nz   = z;
    g    = DEFAULT_GAIN;
    if (att) begin
      g = gain_cfg.force_limit;
    end else begin
      case (z)
        ZONE_OUTSIDE: begin
          if (d > r1p) begin
            g = '0;
          end else if (d >= r1) begin
            nz = ZONE_OUTER;
            g  = '0;
          end
        end
        ZONE_OUTER: begin
          if (d <= r1p && d >= r1) begin
            if (prev == ZONE_CENTER) g = ramp_force(gain_cfg.outer_intercept, d);
            else if (prev == ZONE_OUTSIDE) g = '0;
          end else begin
            g  = '0;
            nz = (d < r1) ? ZONE_CENTER : ZONE_OUTSIDE;
          end
        end
        ZONE_CENTER: begin
          if (d < r1 && d > r2) begin
            if (prev == ZONE_OUTER) g = '0;
            else if (prev == ZONE_INNER) g = gain_cfg.force_limit;
          end else if (d >= r1) begin
            nz = ZONE_OUTER;
            g  = (prev == ZONE_INNER) ? ramp_force(gain_cfg.outer_intercept, d) : '0;
          end else begin
            nz = ZONE_INNER;
            g  = (prev == ZONE_OUTER) ? ramp_force(gain_cfg.inner_intercept, d)
                                      : gain_cfg.force_limit;
          end
        end
        ZONE_INNER: begin
          if (d <= r2 && d >= r2p) begin
            if (prev == ZONE_CENTER) g = ramp_force(gain_cfg.inner_intercept, d);
            else if (prev == ZONE_INSIDE) g = gain_cfg.force_limit;
          end else begin
            g  = gain_cfg.force_limit;
            nz = (d < r2p) ? ZONE_INSIDE : ZONE_CENTER;
          end
        end
        default: begin
          g = gain_cfg.force_limit;
          if (d < r2p) nz = ZONE_INSIDE;
          else if (d <= r2) nz = ZONE_INNER;
        end
      endcase
      if (nz != z) begin
        from_zone[ch] = z;
        cur_zone[ch]  = nz;
      end
    end
    expected_gains.push_back('{gain: g, zone: nz, attached: att});
  endtask

  task automatic send_sample(input logic ch, input logic [DIST_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_force_gain(ch, d);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_gains.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_OUTER_RADIUS:    gain_cfg.outer_radius    = data[DIST_W-1:0];
      REG_OUTER_BAND_EDGE: gain_cfg.outer_band_edge = data[DIST_W-1:0];
      REG_INNER_RADIUS:    gain_cfg.inner_radius    = data[DIST_W-1:0];
      REG_INNER_BAND_EDGE: gain_cfg.inner_band_edge = data[DIST_W-1:0];
      REG_SLOPE:           gain_cfg.slope           = data;
      REG_OUTER_INTERCEPT: gain_cfg.outer_intercept = data;
      REG_INNER_INTERCEPT: gain_cfg.inner_intercept = data;
      REG_FORCE_LIMIT:     gain_cfg.force_limit     = data[FORCE_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // 16-bit registers get random junk in the unused top byte
  task automatic load_config(input logic [15:0] r1, input logic [15:0] r1p,
                             input logic [15:0] r2, input logic [15:0] r2p,
                             input logic [23:0] slope, input logic [23:0] outer_icpt,
                             input logic [23:0] inner_icpt, input logic [15:0] limit);
    write_reg(REG_OUTER_RADIUS,    {8'($urandom_range(255)), r1});
    write_reg(REG_OUTER_BAND_EDGE, {8'($urandom_range(255)), r1p});
    write_reg(REG_INNER_RADIUS,    {8'($urandom_range(255)), r2});
    write_reg(REG_INNER_BAND_EDGE, {8'($urandom_range(255)), r2p});
    write_reg(REG_SLOPE,           slope);
    write_reg(REG_OUTER_INTERCEPT, outer_icpt);
    write_reg(REG_INNER_INTERCEPT, inner_icpt);
    write_reg(REG_FORCE_LIMIT,     {8'($urandom_range(255)), limit});
  endtask

  task automatic load_random_config();
    int r2p, r2, r1, r1p;
    logic [23:0] slope;
    if ($urandom_range(99) < 80) begin
      r2p = $urandom_range(20000);
      r2  = r2p + $urandom_range(3000);
      r1  = r2 + $urandom_range(3000);
      r1p = r1 + $urandom_range(3000);
    end else begin
      r2p = $urandom_range(65535);
      r2  = $urandom_range(65535);
      r1  = $urandom_range(65535);
      r1p = $urandom_range(65535);
    end
    if ($urandom_range(99) < 70) slope = 24'(-int'($urandom_range(200000, 1)));
    else slope = 24'($urandom);
    load_config(16'(r1), 16'(r1p), 16'(r2), 16'(r2p), slope,
                ($urandom_range(1) != 0) ? 24'($urandom_range(40000)) : 24'($urandom),
                ($urandom_range(1) != 0) ? 24'($urandom_range(40000)) : 24'($urandom),
                16'($urandom_range(65535)));
  endtask

  function automatic logic [DIST_W-1:0] noise_distance(input int lo, input int hi);
    int pick;
    case ($urandom_range(4))
      0: pick = $urandom_range(65535);
      1: begin
        case ($urandom_range(3))
          0: pick = gain_cfg.outer_radius;
          1: pick = gain_cfg.outer_band_edge;
          2: pick = gain_cfg.inner_radius;
          default: pick = gain_cfg.inner_band_edge;
        endcase
        pick = pick + int'($urandom_range(2)) - 1;
      end
      2: pick = 0;
      3: pick = 65535;
      default: pick = $urandom_range(hi, lo);
    endcase
    if (pick < 0) pick = 0;
    if (pick > 65535) pick = 65535;
    return 16'(pick);
  endfunction

  // Each channel sweeps in through the bands and back out; a few items are noise.
  task automatic send_sweep_items(input int count);
    int lo, hi, stepw, delta;
    logic ch;
    logic [DIST_W-1:0] d;
    lo = gain_cfg.inner_band_edge;
    hi = gain_cfg.inner_band_edge;
    if (gain_cfg.inner_radius < lo) lo = gain_cfg.inner_radius;
    if (gain_cfg.outer_radius < lo) lo = gain_cfg.outer_radius;
    if (gain_cfg.outer_band_edge < lo) lo = gain_cfg.outer_band_edge;
    if (gain_cfg.inner_radius > hi) hi = gain_cfg.inner_radius;
    if (gain_cfg.outer_radius > hi) hi = gain_cfg.outer_radius;
    if (gain_cfg.outer_band_edge > hi) hi = gain_cfg.outer_band_edge;
    stepw = (hi - lo) / 10 + 1;
    for (int c = 0; c < CHANNELS; c++) begin
      sweep_pos[c] = (hi + stepw > 65535) ? 65535 : hi + stepw;
      sweep_in[c]  = 1'b1;
    end
    for (int i = 0; i < count; i++) begin
      ch = 1'($urandom_range(1));
      if ($urandom_range(99) < 15) begin
        d = noise_distance(lo, hi);
      end else begin
        delta = $urandom_range(2 * stepw, 1);
        sweep_pos[ch] = sweep_in[ch] ? sweep_pos[ch] - delta : sweep_pos[ch] + delta;
        if (sweep_pos[ch] <= lo - stepw || sweep_pos[ch] <= 0) sweep_in[ch] = 1'b0;
        if (sweep_pos[ch] >= hi + stepw || sweep_pos[ch] >= 65535) sweep_in[ch] = 1'b1;
        if (sweep_pos[ch] < 0) sweep_pos[ch] = 0;
        if (sweep_pos[ch] > 65535) sweep_pos[ch] = 65535;
        d = 16'(sweep_pos[ch]);
      end
      send_sample(ch, d);
    end
  endtask

  task automatic test_zone_walk();
    bit walk_ch [23] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                         0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0};
    int walk_d  [23] = '{65535, 65535, 3113, 3000, 2457, 2000, 1475, 1000,
                         818, 819, 1000, 1476, 2000, 2458, 3000, 3114, 0,
                         0, 100, 65535, 2458, 0, 0};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 23; i++) send_sample(walk_ch[i], 16'(walk_d[i]));
    drain();
  endtask

  task automatic test_register_extremes();
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    load_config(16'd0, 16'd0, 16'd0, 16'd0, 24'd0, 24'd0, 24'd0, 16'd0);
    send_sweep_items(60);
    drain();
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF,
                24'h800000, 16'hFFFF);
    send_sweep_items(60);
    drain();
    load_config(16'd2458, 16'd3113, 16'd1475, 16'd819, 24'h800000, 24'd0,
                24'h7FFFFF, 16'hFFFF);
    send_sweep_items(60);
    drain();
    // thresholds out of order: several cases fall through to the default gain
    load_config(16'd1000, 16'd500, 16'd3000, 16'd4000, 24'(-96000), 24'd18240,
                24'd8640, 16'd3840);
    send_sweep_items(60);
    drain();
    write_reg(REG_PAST_END, 24'($urandom));
    write_reg(REG_UNUSED, 24'($urandom));
    load_config(16'd2458, 16'd3113, 16'd1475, 16'd819, 24'(-96000), 24'd18240,
                24'd8640, 16'd3840);
    send_sweep_items(60);
    drain();
  endtask

  task automatic test_idle_patterns();
    int idle_mix  [4] = '{0, 78, 0, 23};
    int stall_mix [4] = '{0, 0, 78, 23};
    for (int p = 0; p < 4; p++) begin
      load_random_config();
      send_idle_pct  = idle_mix[p];
      recv_stall_pct = stall_mix[p];
      send_sweep_items(450);
      drain();
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left <= 150;
    send_sweep_items(40);
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off_left > 0) begin
      m_tready      <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    gain_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_gains.size() == 0) begin
        $error("unexpected result transaction: m_tdata=%h m_tuser=%b", m_tdata, m_tuser);
        mismatch_count++;
      end else begin
        want = expected_gains.pop_front();
        if (m_tdata[15:0] !== want.gain) begin
          $error("gain mismatch: expected %0d, actual %0d", want.gain, m_tdata[15:0]);
          mismatch_count++;
        end
        if (m_tdata[18:16] !== want.zone) begin
          $error("zone mismatch: expected %0d, actual %0d", want.zone, m_tdata[18:16]);
          mismatch_count++;
        end
        if (m_tuser !== want.attached) begin
          $error("attached mismatch: expected %0d, actual %0d", want.attached, m_tuser);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("FAIL haptic_zone_force_gain");
    $finish;
  end

  initial begin
    gain_cfg = '{outer_radius: 16'd2458, outer_band_edge: 16'd3113,
                 inner_radius: 16'd1475, inner_band_edge: 16'd819,
                 slope: -24'sd96000, outer_intercept: 24'sd18240,
                 inner_intercept: 24'sd8640, force_limit: 16'd3840};
    for (int c = 0; c < CHANNELS; c++) begin
      cur_zone[c]  = ZONE_OUTSIDE;
      from_zone[c] = ZONE_OUTSIDE;
      seen_dist[c] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_zone_walk();
    test_register_extremes();
    test_idle_patterns();
    test_output_backpressure();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS haptic_zone_force_gain");
    end else begin
      $display("FAIL haptic_zone_force_gain");
    end
    $finish;
  end

endmodule
